FILE: hw/rtl/mpq_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mpq_pkg
// Shared types and codes of the minimum priority queue.
// ---------------------------------------------------------------------------
package mpq_pkg;

   // default number of entries held
   localparam int CAPACITY_DEFAULT = 128;

   localparam int DATA_W  = 32;
   localparam int PRIO_W  = 32;
   localparam int COUNT_W = 8;

   // operation requested by an input transfer
   typedef enum logic [0:0] {
      KIND_INSERT = 1'b0,
      KIND_REMOVE = 1'b1
   } kind_type;

   // status reported with every result
   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_FULL     = 2'd1,
      ST_REMOVED  = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   // one stored entry
   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic [PRIO_W-1:0] prio;
   } entry_type;

   // broadcast command from the control to every cell
   typedef struct packed {
      logic insert;
      logic remove;
   } cell_ctrl_type;

endpackage
`default_nettype wire

FILE: hw/rtl/mpq_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mpq_if
// Valid/ready channels of the minimum priority queue: request and response.
// ---------------------------------------------------------------------------
interface mpq_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic signed [31:0] item_data;
   logic signed [31:0] item_priority;

   modport source (output valid, output kind, output item_data, output item_priority,
                   input ready);
   modport sink   (input valid, input kind, input item_data, input item_priority,
                   output ready);
endinterface

interface mpq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic signed [31:0] removed_data;
   logic signed [31:0] removed_priority;
   logic [7:0]  entry_count;

   modport source (output valid, output status, output removed_data,
                   output removed_priority, output entry_count, input ready);
   modport sink   (input valid, input status, input removed_data,
                   input removed_priority, input entry_count, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/mpq_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mpq_cell
// One slot of the sorted chain. Holds an entry, shifts right on insert when
// the new entry is strictly more urgent, shifts left on remove.
// ---------------------------------------------------------------------------
module mpq_cell #(
   parameter int INDEX   = 0,
   parameter int COUNT_W = 8
) (
   input  wire                           clock,
   input  wire mpq_pkg::cell_ctrl_type   ctrl,
   input  wire mpq_pkg::entry_type       new_entry,
   input  wire [COUNT_W-1:0]             count,
   input  wire mpq_pkg::entry_type       left_entry,
   input  wire                           left_shift,
   input  wire mpq_pkg::entry_type       right_entry,
   output mpq_pkg::entry_type            entry_out,
   output logic                          shift_out
);

   localparam logic [COUNT_W-1:0] MY_INDEX = COUNT_W'(INDEX);

   mpq_pkg::entry_type entry_ff;
   mpq_pkg::entry_type entry_in;
   logic               occupied;
   logic               place;

   // slot is in use and the new entry goes ahead of it (ties stay behind)
   assign occupied  = count > MY_INDEX;
   assign shift_out = occupied && ($signed(new_entry.prio) < $signed(entry_ff.prio));
   assign place     = shift_out || (count == MY_INDEX);

   // next entry: neighbor on shift, new entry at the insert point
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert && place) begin
         entry_in = left_shift ? left_entry : new_entry;
      end else if (ctrl.remove) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_out = entry_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/min_priority_queue_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// min_priority_queue_top
// Bounded minimum priority queue built as a sorted chain of cells.
// ---------------------------------------------------------------------------
// the response is registered: response valid rises in the cycle after the request transfer
// throughput: one request per cycle with responses taken; the chain inserts or
//   removes in a single step and the response register frees as it is taken
// reset clears the entry count and the response valid; entry contents are
//   not cleared and no clearing pass runs
// ---------------------------------------------------------------------------
module min_priority_queue_top #(
   parameter int CAPACITY = mpq_pkg::CAPACITY_DEFAULT
) (
   input  wire      clock,
   input  wire      reset,
   mpq_req_if.sink  req_chan,
   mpq_rsp_if.source rsp_chan
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

   logic [CW-1:0]          count_ff;
   logic [CW-1:0]          count_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [1:0]             status_ff;
   logic [1:0]             status_in;
   logic [31:0]            rdata_ff;
   logic [31:0]            rdata_in;
   logic [31:0]            rprio_ff;
   logic [31:0]            rprio_in;
   logic [7:0]             rcount_ff;
   logic [7:0]             rcount_in;

   logic                   accept;
   logic                   full;
   logic                   empty;
   mpq_pkg::cell_ctrl_type ctrl;
   mpq_pkg::entry_type     new_entry;
   mpq_pkg::entry_type     cell_entry [CAPACITY];
   logic                   cell_shift [CAPACITY];

   // request transfer when the response slot is free or being taken
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign full           = count_ff == CAP_COUNT;
   assign empty          = count_ff == '0;

   assign ctrl.insert = accept && (req_chan.kind == mpq_pkg::KIND_INSERT) && !full;
   assign ctrl.remove = accept && (req_chan.kind == mpq_pkg::KIND_REMOVE) && !empty;

   assign new_entry.data = req_chan.item_data;
   assign new_entry.prio = req_chan.item_priority;

   // chain of cells, head at index zero
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      mpq_pkg::entry_type left_e;
      mpq_pkg::entry_type right_e;
      logic               left_s;
      if (i == 0) begin : g_head
         assign left_e = '0;
         assign left_s = 1'b0;
      end else begin : g_mid
         assign left_e = cell_entry[i-1];
         assign left_s = cell_shift[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign right_e = '0;
      end else begin : g_body
         assign right_e = cell_entry[i+1];
      end
      mpq_cell #(
         .INDEX   (i),
         .COUNT_W (CW)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .new_entry   (new_entry),
         .count       (count_ff),
         .left_entry  (left_e),
         .left_shift  (left_s),
         .right_entry (right_e),
         .entry_out   (cell_entry[i]),
         .shift_out   (cell_shift[i])
      );
   end

   // count and response register
   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      status_in    = status_ff;
      rdata_in     = rdata_ff;
      rprio_in     = rprio_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rdata_in     = '0;
         rprio_in     = '0;
         case (req_chan.kind)
            mpq_pkg::KIND_INSERT: begin
               if (full) begin
                  status_in = mpq_pkg::ST_FULL;
               end else begin
                  status_in = mpq_pkg::ST_INSERTED;
                  count_in  = count_ff + 1'b1;
               end
            end
            mpq_pkg::KIND_REMOVE: begin
               if (empty) begin
                  status_in = mpq_pkg::ST_EMPTY;
               end else begin
                  status_in = mpq_pkg::ST_REMOVED;
                  rdata_in  = cell_entry[0].data;
                  rprio_in  = cell_entry[0].prio;
                  count_in  = count_ff - 1'b1;
               end
            end
            default: begin
               status_in = mpq_pkg::ST_EMPTY;
            end
         endcase
      end
      rcount_in = accept ? 8'(count_in) : rcount_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      rdata_ff  <= rdata_in;
      rprio_ff  <= rprio_in;
      rcount_ff <= rcount_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.status           = status_ff;
   assign rsp_chan.removed_data     = rdata_ff;
   assign rsp_chan.removed_priority = rprio_ff;
   assign rsp_chan.entry_count      = rcount_ff;

   // count never passes capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_COUNT)
      else $error("entry count above capacity");

   // a remove on a non-empty queue drops the count by one
   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.remove |=> (count_ff + 1'b1) == $past(count_ff))
      else $error("remove did not drop the count");

   // a full response is only given with the store at capacity
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.kind == mpq_pkg::KIND_INSERT && full)
         |=> (status_ff == mpq_pkg::ST_FULL) && (count_ff == CAP_COUNT))
      else $error("full status with store below capacity");

   // insert and remove never fire together
   a_ctrl_excl: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.insert && ctrl.remove))
      else $error("insert and remove in the same cycle");

endmodule
`default_nettype wire
